### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jcrd_pkg.sv
// Package: constants, zigzag table, store control type and FSM type.
`timescale 1ns / 1ps

package jcrd_pkg;

  localparam int VALUE_BITS_DEFAULT = 16;
  localparam int BLOCK_LEN          = 64;
  localparam int IDX_W              = 6;
  localparam int POS_W              = 7;
  localparam int COEF_W             = 16;
  localparam int SYM_W              = 8;
  localparam int EXTRA_W            = 15;
  localparam int SIZE_W             = 4;

  localparam logic REQ_DC = 1'b0;
  localparam logic REQ_AC = 1'b1;

  localparam logic [IDX_W-1:0] FIRST_AC = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_LEN - 1);
  localparam logic [SYM_W-1:0] SYM_EOB  = '0;

  typedef logic [IDX_W-1:0] zz_tab_t [BLOCK_LEN];

  localparam zz_tab_t ZZ_TO_NAT = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  function automatic logic [IDX_W-1:0] zz_to_nat(input logic [IDX_W-1:0] zz);
    return ZZ_TO_NAT[zz];
  endfunction

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } store_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

### rtl/jcrd_sym_if.sv
// Input channel: one decoded symbol item per handshake.
`timescale 1ns / 1ps

interface jcrd_sym_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [jcrd_pkg::SYM_W-1:0]     symbol;
  logic [jcrd_pkg::EXTRA_W-1:0]   extra_bits;

  modport source (output valid, req_type, symbol, extra_bits, input ready);
  modport sink   (input valid, req_type, symbol, extra_bits, output ready);
endinterface

### rtl/jcrd_coef_if.sv
// Output channel: one coefficient item per handshake.
`timescale 1ns / 1ps

interface jcrd_coef_if;
  logic                               valid;
  logic                               ready;
  logic [jcrd_pkg::IDX_W-1:0]         coef_index;
  logic signed [jcrd_pkg::COEF_W-1:0] coef_value;
  logic                               last;
  logic                               overrun;

  modport source (output valid, coef_index, coef_value, last, overrun, input ready);
  modport sink   (input valid, coef_index, coef_value, last, overrun, output ready);
endinterface

### rtl/jpeg_coefficient_run_decode_unit.sv
// Top level: JPEG run-length coefficient decode into an 8x8 block.
`timescale 1ns / 1ps

// Usage:
//   sym  - input items: req_type (DC/AC), symbol, extra_bits. A DC item
//          starts a block at coefficient 0; AC items place run/size values
//          in zigzag order.
//   coef - output items: 64 coefficients per block, natural order, with
//          last on index 63 and overrun on every item of an overrun block.
//   A DC or a non-final AC item is taken and written into the store; sym.ready
//   stays high for the next one. An EOB, the write at position 63 or an
//   overrun starts emission: one store read per cycle while the output
//   register is free or taken, with sym.ready low until the last read.
//   The first coefficient follows the closing item through the state
//   register, the memory read, then the output register.
//   The store read pointer only advances when the output register is free
//   or taken, so a stall on coef holds emission; the next block's items are
//   taken while the final two coefficients drain.
//   Reset (rst, synchronous) empties the store, sets the position to one
//   and drops any pending output.

module jpeg_coefficient_run_decode_unit #(
  parameter int VALUE_BITS = jcrd_pkg::VALUE_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  jcrd_sym_if.sink   sym,
  jcrd_coef_if.source coef
);

  jcrd_pkg::state_t                state;
  logic [jcrd_pkg::IDX_W-1:0]      zp;
  logic                            overrun_seen;
  logic [jcrd_pkg::IDX_W-1:0]      cnt;

  logic                            rd_valid;
  logic [jcrd_pkg::IDX_W-1:0]      rd_idx;
  logic                            rd_last;
  logic                            rd_ovr;

  jcrd_pkg::store_ctl_t            ctl;
  logic [VALUE_BITS-1:0]           wr_data;
  logic [VALUE_BITS-1:0]           rd_data;
  logic signed [VALUE_BITS-1:0]    rd_s;

  logic                            acc;
  logic                            is_dc;
  logic                            is_eob;
  logic [jcrd_pkg::POS_W-1:0]      pos;
  logic                            over;
  logic                            do_write_ac;
  logic                            emit_start;
  logic                            adv;
  logic                            issue;
  logic                            issue_end;

  assign sym.ready = (state == jcrd_pkg::ST_IDLE);
  assign acc       = sym.valid && sym.ready;
  assign is_dc     = (sym.req_type == jcrd_pkg::REQ_DC);
  assign is_eob    = (sym.symbol == jcrd_pkg::SYM_EOB);
  assign pos       = {1'b0, zp} + jcrd_pkg::POS_W'(sym.symbol[7:4]);
  assign over      = pos[jcrd_pkg::POS_W-1];
  assign do_write_ac = acc && !is_dc && !is_eob && !over;
  assign emit_start  = acc && !is_dc &&
                       (is_eob || over || pos[jcrd_pkg::IDX_W-1:0] == jcrd_pkg::LAST_IDX);

  assign adv       = !coef.valid || coef.ready;
  assign issue     = (state == jcrd_pkg::ST_EMIT) && adv;
  assign issue_end = issue && (cnt == jcrd_pkg::LAST_IDX);

  always_comb begin
    ctl.clear   = (acc && is_dc) || issue_end;
    ctl.wr_en   = (acc && is_dc) || do_write_ac;
    ctl.wr_addr = is_dc ? '0 : jcrd_pkg::zz_to_nat(pos[jcrd_pkg::IDX_W-1:0]);
    ctl.rd_en   = issue;
    ctl.rd_addr = cnt;
  end

  jcrd_extend #(.VALUE_BITS(VALUE_BITS)) u_ext (
    .size  (sym.symbol[3:0]),
    .bits  (sym.extra_bits),
    .value (wr_data)
  );

  jcrd_store #(.VALUE_BITS(VALUE_BITS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= jcrd_pkg::ST_IDLE;
      zp           <= jcrd_pkg::FIRST_AC;
      overrun_seen <= 1'b0;
      cnt          <= '0;
    end else begin
      unique case (state)
        jcrd_pkg::ST_IDLE: begin
          if (acc && is_dc) begin
            zp           <= jcrd_pkg::FIRST_AC;
            overrun_seen <= 1'b0;
          end else if (do_write_ac) begin
            zp <= pos[jcrd_pkg::IDX_W-1:0] + jcrd_pkg::IDX_W'(1);
          end
          if (emit_start) begin
            state        <= jcrd_pkg::ST_EMIT;
            overrun_seen <= over;
            cnt          <= '0;
          end
        end
        jcrd_pkg::ST_EMIT: begin
          if (issue) begin
            cnt <= cnt + jcrd_pkg::IDX_W'(1);
          end
          if (issue_end) begin
            state        <= jcrd_pkg::ST_IDLE;
            zp           <= jcrd_pkg::FIRST_AC;
            overrun_seen <= 1'b0;
          end
        end
        default: state <= jcrd_pkg::ST_IDLE;
      endcase
    end
  end

  // Read stage and output register move together whenever the output is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      coef.valid <= 1'b0;
    end else if (adv) begin
      rd_valid   <= issue;
      coef.valid <= rd_valid;
    end
  end

  assign rd_s = rd_data;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_idx          <= cnt;
      rd_last         <= (cnt == jcrd_pkg::LAST_IDX);
      rd_ovr          <= overrun_seen;
      coef.coef_index <= rd_idx;
      coef.coef_value <= jcrd_pkg::COEF_W'(rd_s);
      coef.last       <= rd_last;
      coef.overrun    <= rd_ovr;
    end
  end

endmodule

### rtl/jcrd_extend.sv
// Size/extra-bits extension to a saturated signed coefficient.
`timescale 1ns / 1ps

module jcrd_extend #(
  parameter int VALUE_BITS = jcrd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic [jcrd_pkg::SIZE_W-1:0]  size,
  input  logic [jcrd_pkg::EXTRA_W-1:0] bits,
  output logic [VALUE_BITS-1:0]        value
);

  localparam int EW = jcrd_pkg::EXTRA_W + 2;
  localparam logic signed [EW-1:0] LIM = EW'((1 << (VALUE_BITS - 1)) - 1);

  logic [jcrd_pkg::EXTRA_W:0]   one_hot;
  logic [jcrd_pkg::EXTRA_W-1:0] mask;
  logic [jcrd_pkg::EXTRA_W-1:0] v;
  logic                         top;
  logic signed [EW-1:0]         raw;
  logic signed [EW-1:0]         sat;

  always_comb begin
    one_hot = (jcrd_pkg::EXTRA_W + 1)'(1) << size;
    mask    = jcrd_pkg::EXTRA_W'(one_hot - (jcrd_pkg::EXTRA_W + 1)'(1));
    v       = bits & mask;
    top     = |({1'b0, v} & (one_hot >> 1));
    if (size == '0) begin
      raw = '0;
    end else if (top) begin
      raw = signed'({2'b00, v});
    end else begin
      raw = signed'({2'b00, v}) - signed'({2'b00, mask});
    end
    if (raw > LIM) begin
      sat = LIM;
    end else if (raw < -LIM) begin
      sat = -LIM;
    end else begin
      sat = raw;
    end
    value = sat[VALUE_BITS-1:0];
  end

endmodule

### rtl/jcrd_store.sv
// Coefficient store: 64-entry synchronous memory with per-entry valid bits.
`timescale 1ns / 1ps

module jcrd_store #(
  parameter int VALUE_BITS = jcrd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  jcrd_pkg::store_ctl_t   ctl,
  input  logic [VALUE_BITS-1:0]  wr_data,
  output logic [VALUE_BITS-1:0]  rd_data
);

  logic [VALUE_BITS-1:0]          mem [jcrd_pkg::BLOCK_LEN];
  logic [jcrd_pkg::BLOCK_LEN-1:0] vld;
  logic [VALUE_BITS-1:0]          rd_q;
  logic                           rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[ctl.rd_addr];
    end
  end

  // Unwritten entries read as zero; a clear drops the whole block at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.clear) begin
        vld <= '0;
      end
      if (ctl.wr_en) begin
        vld[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= vld[ctl.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

### rtl/jcrd_checker.sv
// Port-level checker for the run decode unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jcrd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [jcrd_pkg::IDX_W-1:0]         coef_index,
  input logic signed [jcrd_pkg::COEF_W-1:0] coef_value,
  input logic                               last
);

  `ASSERT_SAME(a_last_on_63, out_valid, last == (coef_index == jcrd_pkg::LAST_IDX), "last not on index 63")
  `ASSERT_SAME(a_no_input_mid_emit, out_valid && coef_index < 6'd62, !in_ready, "input taken during emission")
  `ASSERT_NEXT(a_index_step, out_valid && out_ready && !last, !out_valid || coef_index == $past(coef_index) + 6'd1, "coefficient index skipped")
  `ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(coef_index) && $stable(coef_value), "output changed while stalled")

endmodule

bind jpeg_coefficient_run_decode_unit jcrd_checker u_jcrd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sym.ready),
  .out_valid  (coef.valid),
  .out_ready  (coef.ready),
  .coef_index (coef.coef_index),
  .coef_value (coef.coef_value),
  .last       (coef.last)
);

### tb/coef_checker.sv
// Checker: watches both channels, predicts each coefficient block and compares.
`timescale 1ns / 1ps

module coef_checker #(
  parameter int VALUE_BITS = jcrd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  jcrd_sym_if  sym,
  jcrd_coef_if coef,
  output int   errors,
  output int   pending,
  output int   checked
);
  import jcrd_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]         pos;
    logic signed [COEF_W-1:0] val;
    logic                     last_flag;
    logic                     ovr_flag;
  } coef_item_t;

  coef_item_t        expected_coefs[$];
  logic [COEF_W-1:0] block_store[BLOCK_LEN];
  int                zz_pos;
  logic              overrun_seen;
  int                err_count;
  int                checked_count;

  // JPEG EXTEND with saturation to the value width
  function automatic logic [COEF_W-1:0] extend_coef(input logic [SIZE_W-1:0] size,
                                                    input logic [EXTRA_W-1:0] raw);
    int lim;
    int mag;
    int v;
    lim = (1 << (VALUE_BITS - 1)) - 1;
    if (size == 0) return '0;
    mag = int'(raw) & ((1 << size) - 1);
    if (((mag >> (size - 1)) & 1) != 0) v = mag;
    else v = mag - (1 << size) + 1;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return COEF_W'(v);
  endfunction

  function automatic void clear_block();
    foreach (block_store[k]) block_store[k] = '0;
    zz_pos       = int'(FIRST_AC);
    overrun_seen = 1'b0;
  endfunction

  function automatic void emit_block();
    coef_item_t entry;
    for (int k = 0; k < BLOCK_LEN; k++) begin
      entry = '{pos: IDX_W'(k), val: block_store[k],
                last_flag: (k == BLOCK_LEN - 1), ovr_flag: overrun_seen};
      expected_coefs.insert(expected_coefs.size(), entry);
    end
    clear_block();
  endfunction

  function automatic void decode_symbol(input logic req, input logic [SYM_W-1:0] s,
                                        input logic [EXTRA_W-1:0] raw);
    int target;
    if (req == REQ_DC) begin
      clear_block();
      block_store[0] = extend_coef(s[SIZE_W-1:0], raw);
      return;
    end
    if (s == SYM_EOB) begin
      emit_block();
      return;
    end
    target = zz_pos + int'(s[SYM_W-1:SIZE_W]);
    if (target > BLOCK_LEN - 1) begin
      overrun_seen = 1'b1;
      emit_block();
      return;
    end
    block_store[ZZ_TO_NAT[target]] = extend_coef(s[SIZE_W-1:0], raw);
    zz_pos = target + 1;
    if (zz_pos > BLOCK_LEN - 1) emit_block();
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    coef_item_t want;
    if (rst) begin
      clear_block();
      expected_coefs.delete();
    end else begin
      if (coef.valid && coef.ready) begin
        checked_count++;
        if (expected_coefs.size() == 0) begin
          note_error($sformatf("unexpected coefficient: idx %0d val %0d last %0b ovr %0b",
                               coef.coef_index, $signed(coef.coef_value), coef.last,
                               coef.overrun));
        end else begin
          want = expected_coefs.pop_front();
          if (coef.coef_index !== want.pos || coef.coef_value !== want.val ||
              coef.last !== want.last_flag || coef.overrun !== want.ovr_flag) begin
            note_error($sformatf({"coef mismatch: exp idx %0d val %0d last %0b ovr %0b,",
                                  " got idx %0d val %0d last %0b ovr %0b"},
                                 want.pos, want.val, want.last_flag, want.ovr_flag,
                                 coef.coef_index, $signed(coef.coef_value), coef.last,
                                 coef.overrun));
          end
        end
      end
      if (sym.valid && sym.ready) decode_symbol(sym.req_type, sym.symbol, sym.extra_bits);
    end
    errors  <= err_count;
    pending <= expected_coefs.size();
    checked <= checked_count;
  end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, symbol stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
  import jcrd_pkg::*;

  localparam int RANDOM_ITEMS = 80;
  localparam int PHASES       = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  int   zz_at = 1;
  logic block_closed = 1'b0;
  int   items_sent = 0;
  int   errors;
  int   pending;
  int   checked;

  jcrd_sym_if  sym_ch ();
  jcrd_coef_if coef_ch ();

  jpeg_coefficient_run_decode_unit dut (
    .clk  (clk),
    .rst  (rst),
    .sym  (sym_ch),
    .coef (coef_ch)
  );

  coef_checker chk (
    .clk     (clk),
    .rst     (rst),
    .sym     (sym_ch),
    .coef    (coef_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    coef_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [EXTRA_W-1:0] rand_bits();
    return EXTRA_W'($urandom_range(0, 32767));
  endfunction

  // run in the high nibble; run 0 with size 0 would be EOB, so bump the size
  function automatic logic [SYM_W-1:0] ac_symbol(input int run);
    logic [SIZE_W-1:0] size;
    size = SIZE_W'($urandom_range(0, 15));
    if (run == 0 && size == 0) size = SIZE_W'(1);
    return {SIZE_W'(run), size};
  endfunction

  // zz_at shadows the block position only to shape the sequences
  task automatic send_sym(input logic req, input logic [SYM_W-1:0] s,
                          input logic [EXTRA_W-1:0] raw);
    int p;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid      <= 1'b1;
    sym_ch.req_type   <= req;
    sym_ch.symbol     <= s;
    sym_ch.extra_bits <= raw;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    items_sent++;
    block_closed = 1'b0;
    if (req == REQ_DC) begin
      zz_at = 1;
    end else if (s == SYM_EOB) begin
      zz_at = 1;
      block_closed = 1'b1;
    end else begin
      p = zz_at + int'(s[SYM_W-1:SIZE_W]);
      if (p >= BLOCK_LEN - 1) begin
        zz_at = 1;
        block_closed = 1'b1;
      end else begin
        zz_at = p + 1;
      end
    end
  endtask

  task automatic drain();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_tab[PHASES];
    int stall_tab[PHASES];
    int target;
    int kind;
    int r;
    idle_tab  = '{0, 80, 0, 16};
    stall_tab = '{0, 0, 80, 16};
    sym_ch.valid      = 1'b0;
    sym_ch.req_type   = REQ_DC;
    sym_ch.symbol     = '0;
    sym_ch.extra_bits = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // extremes of the value range, extra bits above the size
    send_sym(REQ_DC, 8'h0F, 15'h7FFF);
    send_sym(REQ_AC, 8'h1F, 15'h0000);
    send_sym(REQ_AC, 8'h01, 15'h0001);
    send_sym(REQ_AC, 8'h01, 15'h0000);
    send_sym(REQ_AC, 8'h0B, 15'h7FFF);
    send_sym(REQ_AC, SYM_EOB, 15'h7FFF);
    // DC symbol with a nonzero high nibble, ZRL, then a DC restart mid-block
    send_sym(REQ_DC, 8'hFA, 15'h0155);
    send_sym(REQ_AC, 8'hF0, 15'h2AAA);
    send_sym(REQ_AC, 8'h23, 15'h0005);
    send_sym(REQ_DC, 8'h05, 15'h001F);
    send_sym(REQ_AC, 8'h31, 15'h0001);
    send_sym(REQ_AC, SYM_EOB, 15'h0000);
    // AC with no DC first
    send_sym(REQ_AC, 8'h52, 15'h0002);
    send_sym(REQ_AC, SYM_EOB, 15'h0000);
    // overrun past position 63
    send_sym(REQ_DC, 8'h03, 15'h0004);
    repeat (3) send_sym(REQ_AC, 8'hF0, rand_bits());
    send_sym(REQ_AC, 8'hF5, 15'h0011);
    // write lands exactly on position 63
    send_sym(REQ_DC, 8'h00, 15'h0000);
    repeat (3) send_sym(REQ_AC, 8'hF0, rand_bits());
    send_sym(REQ_AC, 8'hE1, 15'h0001);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = idle_tab[ph];
      recv_stall_pct  = stall_tab[ph];
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
          repeat (3) send_sym(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                              rand_bits());
        end else begin
          if (kind != 8) send_sym(REQ_DC, SYM_W'($urandom_range(0, 255)), rand_bits());
          repeat ($urandom_range(0, 6)) send_sym(REQ_AC, ac_symbol($urandom_range(0, 3)),
                                                 rand_bits());
          case (kind)
            5: begin
              do begin
                r = $urandom_range(0, (BLOCK_LEN - 1 - zz_at) < 15 ?
                                      (BLOCK_LEN - 1 - zz_at) : 15);
                send_sym(REQ_AC, ac_symbol(r), rand_bits());
              end while (!block_closed);
            end
            6: begin
              while (zz_at + 15 <= BLOCK_LEN - 1) begin
                send_sym(REQ_AC, {4'hF, SIZE_W'($urandom_range(0, 15))}, rand_bits());
              end
              send_sym(REQ_AC, ac_symbol($urandom_range(BLOCK_LEN - zz_at, 15)),
                       rand_bits());
            end
            7: begin
              send_sym(REQ_DC, SYM_W'($urandom_range(0, 255)), rand_bits());
              repeat ($urandom_range(1, 4)) send_sym(REQ_AC, ac_symbol($urandom_range(0, 3)),
                                                     rand_bits());
              send_sym(REQ_AC, SYM_EOB, rand_bits());
            end
            default: send_sym(REQ_AC, SYM_EOB, rand_bits());
          endcase
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d symbol items: value extremes, restarts, ZRL, exact fill, overrun",
             items_sent);
    $display("and random blocks; %0d coefficients checked under four idle/stall mixes",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
